FILE: rtl/core/t2ls_pkg.sv
package t2ls_pkg;

    // Register file geometry
    localparam int unsigned REG_COUNT = 16;
    localparam int unsigned REG_IDX_W = 4;
    localparam int unsigned DATA_W    = 32;

    // Result status codes
    typedef enum logic [1:0] {
        ST_ACCESS  = 2'd0,
        ST_FAULT   = 2'd1,
        ST_NONE    = 2'd2,
        ST_WRITTEN = 2'd3
    } t_status;

    // One result item
    typedef struct packed {
        t_status               status;
        logic                  is_load;
        logic [DATA_W-1:0]     address;
        logic [REG_IDX_W-1:0]  target_reg;
        logic                  access_size;
        logic                  base_updated;
    } t_result;

    // Register file write request (register write item or base writeback)
    typedef struct packed {
        logic                  en;
        logic [REG_IDX_W-1:0]  idx;
        logic [DATA_W-1:0]     data;
    } t_rf_wr;

endpackage

FILE: rtl/core/thumb2_load_store_address_decoder.sv
// Thumb-2 load/store address decoder. Register-write items (kind 0) load a 16 x 32-bit
// register file, which is all zero after reset; decode items (kind 1) classify a 32-bit
// Thumb-2 instruction (first halfword in bits 15:0) and report direction, effective
// address, Rt and size for STRB/STR and the supported LDR forms, with base writeback for
// LDR imm8 when W is set. Every item yields exactly one result item. The accepting edge
// registers the item in stage 1 together with the Rn and Rm reads from the register file
// RAMs (registered read); the decode and the single address adder then feed the output
// register, which captures them when it is empty or i_ready is high. One item is
// accepted per cycle when the output side is not stalled; a register written by the
// previous item is forwarded to the next one.
module thumb2_load_store_address_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_kind,
    input  logic [31:0] i_instruction,
    input  logic [3:0]  i_reg_index,
    input  logic [31:0] i_reg_value,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic        o_is_load,
    output logic [31:0] o_address,
    output logic [3:0]  o_target_reg,
    output logic        o_access_size,
    output logic        o_base_updated
);

    import t2ls_pkg::*;

    logic                  accept;
    logic                  advance;

    // Stage 1: item held while RAM read data arrives
    logic                  r_s1_valid;
    logic                  r_s1_kind;
    logic [31:0]           r_s1_inst;
    logic [REG_IDX_W-1:0]  r_s1_reg_index;
    logic [DATA_W-1:0]     r_s1_reg_value;
    logic                  r_s1_vld_n;
    logic                  r_s1_vld_m;

    // Write that landed on the edge this item was accepted
    logic                  r_fwd_valid;
    logic [REG_IDX_W-1:0]  r_fwd_idx;
    logic [DATA_W-1:0]     r_fwd_data;

    logic [REG_COUNT-1:0]  r_written;

    logic [DATA_W-1:0]     ram_n;
    logic [DATA_W-1:0]     ram_m;
    logic [DATA_W-1:0]     base;
    logic [DATA_W-1:0]     rm_value;

    t_result               result;
    t_rf_wr                rf_wr;
    t_rf_wr                wr_q;

    // Output register
    logic                  r_out_valid;
    t_result               r_out;

    assign advance = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_s1_valid || advance;
    assign accept  = i_valid && o_ready;
    assign wr_q    = advance ? rf_wr : '0;

    // Two copies of the register file, one per read port
    t2ls_ram #(
        .P_WIDTH (DATA_W),
        .P_DEPTH (REG_COUNT)
    ) u_ram_n (
        .i_clk     (i_clk),
        .i_wr_en   (wr_q.en),
        .i_wr_addr (wr_q.idx),
        .i_wr_data (wr_q.data),
        .i_rd_en   (accept),
        .i_rd_addr (i_instruction[3:0]),
        .o_rd_data (ram_n)
    );

    t2ls_ram #(
        .P_WIDTH (DATA_W),
        .P_DEPTH (REG_COUNT)
    ) u_ram_m (
        .i_clk     (i_clk),
        .i_wr_en   (wr_q.en),
        .i_wr_addr (wr_q.idx),
        .i_wr_data (wr_q.data),
        .i_rd_en   (accept),
        .i_rd_addr (i_instruction[19:16]),
        .o_rd_data (ram_m)
    );

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_written   <= '0;
        end else begin
            if (accept) begin
                r_s1_valid  <= 1'b1;
                r_fwd_valid <= wr_q.en;
            end else if (advance) begin
                r_s1_valid  <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (wr_q.en) begin
                r_written[wr_q.idx] <= 1'b1;
            end
        end
    end

    // Stage 1 payload, sampled with the RAM read
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_kind      <= i_kind;
            r_s1_inst      <= i_instruction;
            r_s1_reg_index <= i_reg_index;
            r_s1_reg_value <= i_reg_value;
            r_s1_vld_n     <= r_written[i_instruction[3:0]];
            r_s1_vld_m     <= r_written[i_instruction[19:16]];
            r_fwd_idx      <= wr_q.idx;
            r_fwd_data     <= wr_q.data;
        end
    end

    // Operand select: forwarded write, then RAM data, zero if never written
    always_comb begin
        if (r_fwd_valid && r_fwd_idx == r_s1_inst[3:0]) begin
            base = r_fwd_data;
        end else begin
            base = r_s1_vld_n ? ram_n : '0;
        end
        if (r_fwd_valid && r_fwd_idx == r_s1_inst[19:16]) begin
            rm_value = r_fwd_data;
        end else begin
            rm_value = r_s1_vld_m ? ram_m : '0;
        end
    end

    t2ls_decode u_decode (
        .i_kind        (r_s1_kind),
        .i_instruction (r_s1_inst),
        .i_reg_index   (r_s1_reg_index),
        .i_reg_value   (r_s1_reg_value),
        .i_base        (base),
        .i_rm_value    (rm_value),
        .o_result      (result),
        .o_rf_wr       (rf_wr)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_out.status;
    assign o_is_load      = r_out.is_load;
    assign o_address      = r_out.address;
    assign o_target_reg   = r_out.target_reg;
    assign o_access_size  = r_out.access_size;
    assign o_base_updated = r_out.base_updated;

endmodule

FILE: rtl/core/t2ls_ram.sv
module t2ls_ram #(
    parameter int unsigned P_WIDTH = 32,
    parameter int unsigned P_DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [$clog2(P_DEPTH)-1:0] i_wr_addr,
    input  logic [P_WIDTH-1:0]         i_wr_data,
    input  logic                       i_rd_en,
    input  logic [$clog2(P_DEPTH)-1:0] i_rd_addr,
    output logic [P_WIDTH-1:0]         o_rd_data
);

    logic [P_WIDTH-1:0] r_mem [P_DEPTH];
    logic [P_WIDTH-1:0] r_rd_data;

    // Single write port, registered read (old data on a same-address collision)
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/core/t2ls_decode.sv
module t2ls_decode (
    input  logic                         i_kind,
    input  logic [31:0]                  i_instruction,
    input  logic [3:0]                   i_reg_index,
    input  logic [31:0]                  i_reg_value,
    input  logic [31:0]                  i_base,
    input  logic [31:0]                  i_rm_value,
    output t2ls_pkg::t_result            o_result,
    output t2ls_pkg::t_rf_wr             o_rf_wr
);

    import t2ls_pkg::*;

    logic [15:0] hw1;
    logic [15:0] hw2;
    logic [1:0]  op1;
    logic [6:0]  op2;
    logic [2:0]  sel_a;
    logic [1:0]  sel_c;
    logic [5:0]  sel_b;
    logic [3:0]  rn;
    logic [31:0] roff;
    logic        rn_pc;

    // Address adder controls
    logic [31:0] offset;
    logic        sub;
    logic        use_base;
    logic [31:0] moved;

    // Decision flags
    logic        acc;
    logic        fault;
    logic        ld;
    logic        word;
    logic        wback;

    assign hw1   = i_instruction[15:0];
    assign hw2   = i_instruction[31:16];
    assign op1   = hw1[12:11];
    assign op2   = hw1[10:4];
    assign sel_a = hw1[7:5];
    assign sel_c = hw1[8:7];
    assign sel_b = hw2[11:6];
    assign rn    = hw1[3:0];
    assign rn_pc = (rn == 4'hF);
    assign roff  = i_rm_value << hw2[5:4];

    // Class and form selection
    always_comb begin
        acc      = 1'b0;
        fault    = 1'b0;
        ld       = 1'b0;
        word     = 1'b0;
        wback    = 1'b0;
        offset   = {20'd0, hw2[11:0]};
        sub      = 1'b0;
        use_base = 1'b0;
        if (op1 == 2'b01) begin
            // load/store multiple, dual, exclusive, table branch
            fault = 1'b1;
        end else if (op1 == 2'b11 && (op2 & 7'h71) == 7'h00) begin
            // store single item
            if (sel_a == 3'b100) begin
                acc = 1'b1;
            end else if (sel_a == 3'b000) begin
                if (sel_b[5]) begin
                    fault = 1'b1;
                end else begin
                    acc    = 1'b1;
                    offset = roff;
                end
            end else if (sel_a == 3'b110) begin
                acc  = 1'b1;
                word = 1'b1;
            end else if (sel_a == 3'b010 && !sel_b[5]) begin
                acc    = 1'b1;
                word   = 1'b1;
                offset = roff;
            end
        end else if (op1 == 2'b11 && (op2 & 7'h67) == 7'h01) begin
            fault = 1'b1;
        end else if (op1 == 2'b11 && (op2 & 7'h67) == 7'h03) begin
            fault = 1'b1;
        end else if (op1 == 2'b11 && (op2 & 7'h67) == 7'h05) begin
            // load word
            ld   = 1'b1;
            word = 1'b1;
            if (sel_c == 2'b01 && !rn_pc) begin
                acc = 1'b1;
            end else if (sel_c == 2'b00 && (sel_b & 6'h24) == 6'h24 && !rn_pc) begin
                // imm8 with P/U/W
                acc      = 1'b1;
                offset   = {24'd0, hw2[7:0]};
                sub      = !hw2[9];
                use_base = !hw2[10];
                wback    = hw2[8];
            end else if (sel_c == 2'b00 && (sel_b & 6'h3C) == 6'h30 && !rn_pc) begin
                fault = 1'b1;
            end else if (sel_c == 2'b00 && (sel_b & 6'h38) == 6'h38 && !rn_pc) begin
                // unprivileged load
                acc    = 1'b1;
                offset = {24'd0, hw2[7:0]};
            end else if (sel_c == 2'b00 && sel_b == 6'd0 && !rn_pc) begin
                acc    = 1'b1;
                offset = roff;
            end else if (!sel_c[1] && rn_pc) begin
                // literal
                acc = 1'b1;
                sub = !hw1[7];
            end
        end else begin
            fault = 1'b1;
        end
    end

    // Single address adder
    assign moved = sub ? (i_base - offset) : (i_base + offset);

    // Result and register file write
    always_comb begin
        o_result = '0;
        o_rf_wr  = '0;
        if (!i_kind) begin
            o_result.status = ST_WRITTEN;
            o_rf_wr.en      = 1'b1;
            o_rf_wr.idx     = i_reg_index;
            o_rf_wr.data    = i_reg_value;
        end else if (acc) begin
            o_result.status       = ST_ACCESS;
            o_result.is_load      = ld;
            o_result.address      = use_base ? i_base : moved;
            o_result.target_reg   = hw2[15:12];
            o_result.access_size  = word;
            o_result.base_updated = wback;
            o_rf_wr.en            = wback;
            o_rf_wr.idx           = rn;
            o_rf_wr.data          = moved;
        end else if (fault) begin
            o_result.status = ST_FAULT;
        end else begin
            o_result.status = ST_NONE;
        end
    end

endmodule

FILE: sim/t2ls_check_pkg.sv
package t2ls_check_pkg;
    import t2ls_pkg::*;

    // item kinds
    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_DECODE = 1'b1;

    // op1 = hw1[12:11] class groups
    localparam logic [1:0] OP1_MULTI  = 2'b01;
    localparam logic [1:0] OP1_SINGLE = 2'b11;

    // op2 = hw1[10:4] class masks
    localparam logic [6:0] OP2_STORE_MASK = 7'h71;
    localparam logic [6:0] OP2_STORE_VAL  = 7'h00;
    localparam logic [6:0] OP2_LOAD_MASK  = 7'h67;
    localparam logic [6:0] OP2_LDRB_VAL   = 7'h01;
    localparam logic [6:0] OP2_LDRH_VAL   = 7'h03;
    localparam logic [6:0] OP2_LDR_VAL    = 7'h05;
    localparam logic [6:0] OP2_LSM_VAL    = 7'h00;
    localparam logic [6:0] OP2_DUAL_VAL   = 7'h04;

    // store single selector a = hw1[7:5]
    localparam logic [2:0] A_STRB_IMM = 3'b100;
    localparam logic [2:0] A_STRB_REG = 3'b000;
    localparam logic [2:0] A_STR_IMM  = 3'b110;
    localparam logic [2:0] A_STR_REG  = 3'b010;
    localparam logic [2:0] A_UNUSED   = 3'b111;

    // load word selector c = hw1[8:7]
    localparam logic [1:0] C_OTHER = 2'b00;
    localparam logic [1:0] C_IMM12 = 2'b01;
    localparam logic [1:0] C_NONE  = 2'b10;

    // b = hw2[11:6] patterns for the load word forms
    localparam logic [5:0] B_IMM8_MASK = 6'b100100;
    localparam logic [5:0] B_NEG_MASK  = 6'b111100;
    localparam logic [5:0] B_NEG_VAL   = 6'b110000;
    localparam logic [5:0] B_USER_MASK = 6'b111000;
    localparam logic [5:0] B_REG       = 6'b000000;

    localparam logic [3:0] PC_IDX  = 4'hF;
    localparam logic       SZ_BYTE = 1'b0;
    localparam logic       SZ_WORD = 1'b1;

    class ls_decode_scoreboard;
        logic [31:0] regs [16];
        t_result     expected_q [$];
        int unsigned errors;
        int unsigned writebacks;
        int unsigned status_seen [4];

        function new();
            foreach (regs[i]) regs[i] = '0;
            foreach (status_seen[i]) status_seen[i] = 0;
            errors     = 0;
            writebacks = 0;
        endfunction

        static function t_result idle_result(t_status st);
            t_result r;
            r        = '0;
            r.status = st;
            return r;
        endfunction

        static function t_result mk_access(logic ld, logic [31:0] addr, logic [3:0] rt,
                                           logic sz, logic wb);
            t_result r;
            r.status       = ST_ACCESS;
            r.is_load      = ld;
            r.address      = addr;
            r.target_reg   = rt;
            r.access_size  = sz;
            r.base_updated = wb;
            return r;
        endfunction

        // STRB / STR, immediate and register offset
        function t_result decode_store(logic [15:0] hw1, logic [15:0] hw2);
            logic [31:0] base;
            logic [31:0] roff;
            base = regs[hw1[3:0]];
            roff = regs[hw2[3:0]] << hw2[5:4];
            case (hw1[7:5])
                A_STRB_IMM: return mk_access(1'b0, base + hw2[11:0], hw2[15:12], SZ_BYTE, 1'b0);
                A_STRB_REG: begin
                    // T3 byte form is not supported
                    if (hw2[11]) return idle_result(ST_FAULT);
                    return mk_access(1'b0, base + roff, hw2[15:12], SZ_BYTE, 1'b0);
                end
                A_STR_IMM:  return mk_access(1'b0, base + hw2[11:0], hw2[15:12], SZ_WORD, 1'b0);
                A_STR_REG: begin
                    if (hw2[11]) return idle_result(ST_NONE);
                    return mk_access(1'b0, base + roff, hw2[15:12], SZ_WORD, 1'b0);
                end
                default:    return idle_result(ST_NONE);
            endcase
        endfunction

        // LDR forms; first matching rule wins
        function t_result decode_load(logic [15:0] hw1, logic [15:0] hw2);
            logic [1:0]  c;
            logic [5:0]  b;
            logic [3:0]  rn;
            logic [3:0]  rt;
            logic [31:0] base;
            logic [31:0] moved;
            c    = hw1[8:7];
            b    = hw2[11:6];
            rn   = hw1[3:0];
            rt   = hw2[15:12];
            base = regs[rn];
            if (c == C_IMM12 && rn != PC_IDX)
                return mk_access(1'b1, base + hw2[11:0], rt, SZ_WORD, 1'b0);
            if (c == C_OTHER && rn != PC_IDX) begin
                if ((b & B_IMM8_MASK) == B_IMM8_MASK) begin
                    // P/U/W in hw2[10:8]; address uses the old base only when P (hw2[10]) is clear
                    moved = hw2[9] ? base + hw2[7:0] : base - hw2[7:0];
                    if (hw2[8]) begin
                        regs[rn] = moved;
                        writebacks++;
                    end
                    return mk_access(1'b1, hw2[10] ? moved : base, rt, SZ_WORD, hw2[8]);
                end
                if ((b & B_NEG_MASK) == B_NEG_VAL)
                    return idle_result(ST_FAULT);
                if ((b & B_USER_MASK) == B_USER_MASK)
                    return mk_access(1'b1, base + hw2[7:0], rt, SZ_WORD, 1'b0);
                if (b == B_REG)
                    return mk_access(1'b1, base + (regs[hw2[3:0]] << hw2[5:4]), rt, SZ_WORD,
                                     1'b0);
            end
            // literal: sign from hw1 bit 7
            if (!c[1] && rn == PC_IDX)
                return mk_access(1'b1, hw1[7] ? base + hw2[11:0] : base - hw2[11:0], rt,
                                 SZ_WORD, 1'b0);
            return idle_result(ST_NONE);
        endfunction

        // Apply one accepted input item and queue its result
        function void note_item(logic kind, logic [31:0] inst, logic [3:0] idx,
                                logic [31:0] val);
            t_result     r;
            logic [15:0] hw1;
            logic [15:0] hw2;
            logic [1:0]  op1;
            logic [6:0]  op2;
            hw1 = inst[15:0];
            hw2 = inst[31:16];
            op1 = hw1[12:11];
            op2 = hw1[10:4];
            if (kind == KIND_WRITE) begin
                regs[idx] = val;
                r = idle_result(ST_WRITTEN);
            end else if (op1 == OP1_SINGLE && (op2 & OP2_STORE_MASK) == OP2_STORE_VAL) begin
                r = decode_store(hw1, hw2);
            end else if (op1 == OP1_SINGLE && (op2 & OP2_LOAD_MASK) == OP2_LDR_VAL) begin
                r = decode_load(hw1, hw2);
            end else begin
                // multiple, dual/exclusive, byte and halfword loads, everything else
                r = idle_result(ST_FAULT);
            end
            expected_q.push_back(r);
        endfunction

        static function bit field_ok(string name, logic [31:0] exp, logic [31:0] got);
            if (got === exp) return 1'b1;
            $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, name, exp, got);
            return 1'b0;
        endfunction

        // Compare one accepted result with the oldest expectation
        function void check_result(t_result got);
            t_result exp;
            bit      ok;
            if (expected_q.size() == 0) begin
                $display("%0t ns: result with nothing outstanding, status %0d", $time,
                         got.status);
                errors++;
                return;
            end
            exp = expected_q.pop_front();
            ok  = field_ok("status", exp.status, got.status);
            ok &= field_ok("is_load", exp.is_load, got.is_load);
            ok &= field_ok("address", exp.address, got.address);
            ok &= field_ok("target_reg", exp.target_reg, got.target_reg);
            ok &= field_ok("access_size", exp.access_size, got.access_size);
            ok &= field_ok("base_updated", exp.base_updated, got.base_updated);
            if (!ok) errors++;
            status_seen[exp.status]++;
        endfunction
    endclass

endpackage

FILE: sim/tb_thumb2_load_store_address_decoder.sv
module tb_thumb2_load_store_address_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import t2ls_pkg::*;
    import t2ls_check_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 1250;
    localparam int unsigned MAX_IDLE     = 12;
    localparam int unsigned DRAIN_CYCLES = 20;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_valid       = 1'b0;
    logic        i_kind        = 1'b0;
    logic [31:0] i_instruction = '0;
    logic [3:0]  i_reg_index   = '0;
    logic [31:0] i_reg_value   = '0;
    logic        i_ready       = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [1:0]  o_status;
    logic        o_is_load;
    logic [31:0] o_address;
    logic [3:0]  o_target_reg;
    logic        o_access_size;
    logic        o_base_updated;

    ls_decode_scoreboard sb;
    bit                  quiet_in;

    always #2 i_clk = ~i_clk;

    thumb2_load_store_address_decoder dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_kind         (i_kind),
        .i_instruction  (i_instruction),
        .i_reg_index    (i_reg_index),
        .i_reg_value    (i_reg_value),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_is_load      (o_is_load),
        .o_address      (o_address),
        .o_target_reg   (o_target_reg),
        .o_access_size  (o_access_size),
        .o_base_updated (o_base_updated)
    );

    // Instruction builders: hw1 in the low half
    function automatic logic [15:0] single_hw1(logic [1:0] op1, logic [6:0] op2,
                                               logic [3:0] rn);
        return {3'b111, op1, op2, rn};
    endfunction

    function automatic logic [31:0] store_inst(logic [2:0] a, logic [3:0] rn,
                                               logic [15:0] hw2);
        return {hw2, single_hw1(OP1_SINGLE, OP2_STORE_VAL | {3'b000, a, 1'b0}, rn)};
    endfunction

    function automatic logic [31:0] load_inst(logic [1:0] c, logic [3:0] rn, logic [15:0] hw2);
        return {hw2, single_hw1(OP1_SINGLE, OP2_LDR_VAL | {2'b00, c, 3'b000}, rn)};
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 3))
            0:       return $urandom();
            1:       return $urandom_range(0, 255);
            2:       return 32'hFFFF_FFFF - $urandom_range(0, 255);
            default: return 32'h8000_0000 | $urandom_range(0, 255);
        endcase
    endfunction

    // Mostly well-formed store/load-word encodings, some raw noise
    function automatic logic [31:0] pick_instruction();
        int unsigned sel;
        logic [3:0]  rn;
        logic [15:0] hw2;
        sel = $urandom_range(0, 99);
        rn  = ($urandom_range(0, 5) == 0) ? PC_IDX : 4'($urandom_range(0, 15));
        hw2 = 16'($urandom());
        if (sel < 40) return store_inst(3'($urandom_range(0, 7)), rn, hw2);
        if (sel < 85) begin
            // lean on the imm8 / LDRT / negative-offset families
            if ($urandom_range(0, 1) == 1) hw2[11] = 1'b1;
            return load_inst(2'($urandom_range(0, 3)), rn, hw2);
        end
        return $urandom();
    endfunction

    // Present one item and hold it until the handshake
    task automatic send_item(logic kind, logic [31:0] inst, logic [3:0] idx, logic [31:0] val);
        int unsigned gap;
        if ($urandom_range(0, 31) == 0) quiet_in = !quiet_in;
        gap = quiet_in ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_kind        <= kind;
        i_instruction <= inst;
        i_reg_index   <= idx;
        i_reg_value   <= val;
        do @(posedge i_clk); while (!o_ready);
        sb.note_item(kind, inst, idx, val);
    endtask

    task automatic send_write(logic [3:0] idx, logic [31:0] val);
        send_item(KIND_WRITE, $urandom(), idx, val);
    endtask

    task automatic send_decode(logic [31:0] inst);
        send_item(KIND_DECODE, inst, 4'($urandom_range(0, 15)), $urandom());
    endtask

    // Stimulus and end of run
    initial begin
        sb       = new();
        quiet_in = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // base values at the extremes
        send_write(4'd0, 32'hFFFF_FFFF);
        send_write(PC_IDX, 32'h0000_1000);
        send_write(4'd3, 32'h8000_0000);
        send_write(4'd4, 32'h0000_0001);
        // stores: byte imm wraps, byte reg, byte T3 fault, word imm, word reg, no action
        send_decode(store_inst(A_STRB_IMM, 4'd0, 16'hFFFF));
        send_decode(store_inst(A_STRB_REG, 4'd3, 16'h5034));
        send_decode(store_inst(A_STRB_REG, 4'd3, 16'h5834));
        send_decode(store_inst(A_STR_IMM, PC_IDX, 16'h0000));
        send_decode(store_inst(A_STR_REG, 4'd0, 16'hA020));
        send_decode(store_inst(A_STR_REG, 4'd0, 16'hA820));
        send_decode(store_inst(A_UNUSED, 4'd0, 16'h1234));
        // loads: imm12, pre-index with writeback, post-index subtract on the new base
        send_decode(load_inst(C_IMM12, 4'd0, 16'h7FFF));
        send_decode(load_inst(C_OTHER, 4'd3, 16'h1FFF));
        send_decode(load_inst(C_OTHER, 4'd3, 16'h2910));
        // negative offset fault, LDRT, register offset, literal minus and plus
        send_decode(load_inst(C_OTHER, 4'd3, 16'h2C01));
        send_decode(load_inst(C_OTHER, 4'd4, 16'h6E80));
        send_decode(load_inst(C_OTHER, 4'd0, 16'h7034));
        send_decode(load_inst(C_OTHER, PC_IDX, 16'h8FFF));
        send_decode(load_inst(C_IMM12, PC_IDX, 16'h8FFF));
        // no action: c=10, and P=0 W=0 in the imm8 family
        send_decode(load_inst(C_NONE, 4'd0, 16'h3456));
        send_decode(load_inst(C_OTHER, 4'd3, 16'h9800));
        // unsupported classes and raw extremes
        send_decode({16'h0000, single_hw1(OP1_SINGLE, OP2_LDRB_VAL, 4'd0)});
        send_decode({16'h0000, single_hw1(OP1_SINGLE, OP2_LDRH_VAL, 4'd0)});
        send_decode({16'h0000, single_hw1(OP1_MULTI, OP2_LSM_VAL, 4'd0)});
        send_decode({16'h0000, single_hw1(OP1_MULTI, OP2_DUAL_VAL, 4'd0)});
        send_decode(32'h0000_0000);
        send_decode(32'hFFFF_FFFF);
        // write then use right away
        send_write(4'd3, 32'h0000_0010);
        send_decode(store_inst(A_STR_IMM, 4'd3, 16'h0001));

        repeat (RANDOM_ITEMS) begin
            if ($urandom_range(0, 3) == 0)
                send_write(4'($urandom_range(0, 15)), pick_value());
            else
                send_decode(pick_instruction());
        end
        i_valid <= 1'b0;

        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Checked %0d accesses (%0d with base writeback), %0d faults,",
                 sb.status_seen[ST_ACCESS], sb.writebacks, sb.status_seen[ST_FAULT]);
        $display("%0d no-action decodes and %0d register writes; %0d failing items",
                 sb.status_seen[ST_NONE], sb.status_seen[ST_WRITTEN], sb.errors);
        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Result side: random back-pressure, check every accepted item
    initial begin : result_sink
        int unsigned stall;
        bit          quiet_out;
        t_result     got;
        quiet_out = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 31) == 0) quiet_out = !quiet_out;
            stall = quiet_out ? 0 : $urandom_range(0, MAX_IDLE);
            if (stall != 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            got = {o_status, o_is_load, o_address, o_target_reg, o_access_size,
                   o_base_updated};
            sb.check_result(got);
        end
    end

    // Hang guard
    initial begin
        #2_000_000;
        $display("Timeout waiting for the block");
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
